// ===== hw/rtl/rfps_pkg.sv =====
package rfps_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEFAULT = 12;

    // apb register map: eight 32-bit registers at byte address 4*i
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [2:0] {
        CFG_RECT_LEFT     = 3'd0,
        CFG_RECT_TOP      = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_COLOR_FIRST   = 3'd4,
        CFG_COLOR_SECOND  = 3'd5,
        CFG_CORNER_RADIUS = 3'd6,
        CFG_FILL_MODE     = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        FILL_SOLID    = 2'd0,
        FILL_ALPHA    = 2'd1,
        FILL_GRADIENT = 2'd2,
        FILL_ROUNDED  = 2'd3
    } t_fill_mode;

    // channel and alpha constants
    localparam logic [7:0]  CHAN_MAX    = 8'hFF;
    localparam logic [7:0]  ALPHA_ZERO  = 8'h00;
    localparam logic [15:0] BLEND_BIAS  = 16'd127;
    // n / 255 == (n * 0x8081) >> 23 for any 16-bit n
    localparam logic [31:0] BLEND_RECIP = 32'h0000_8081;
    localparam int          BLEND_SHIFT = 23;

    // gradient position t in 0..256
    localparam int GRAD_T_BITS = 9;
    // bias that turns the arithmetic shift by 8 into truncation toward zero
    localparam logic signed [18:0] GRAD_NEG_BIAS = 19'sd255;

endpackage

// ===== hw/rtl/rect_fill_pixel_shader.sv =====
// Rectangle fill pixel shader. Takes one surface pixel (column, row, current
// xRGB value) per clock while o_stall is low and returns whether that pixel
// is written and its new value. It runs a six-stage pipeline in which the
// gradient divide row*256/(height-1) runs as a restoring divider with three
// quotient bits per stage and the alpha divide by 255 is a reciprocal
// multiply. Pixels outside the rectangle, or any pixel while width or height
// is zero, come back with write enable low and a zero value. Modes: solid,
// alpha blend over the current pixel, vertical two-color gradient, and solid
// with rounded corners. The user must see that registers are written over the
// APB port only while no pixel is in flight; the block does not enforce this.
// o_stall rises only when the output is held and every stage is full.
module rect_fill_pixel_shader #(
    parameter int COORD_BITS = rfps_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rfps_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [rfps_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [rfps_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,

    // pixel input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [COORD_BITS-1:0]               i_pixel_x,
    input  logic [COORD_BITS-1:0]               i_pixel_y,
    input  logic [31:0]                         i_old_pixel,

    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_write_enable,
    output logic [31:0]                         o_new_pixel
);

    localparam int SizeBits = COORD_BITS + 1;
    localparam int RemBits  = COORD_BITS + 1;
    localparam int SqBits   = 2 * COORD_BITS;
    localparam int TBits    = rfps_pkg::GRAD_T_BITS;
    localparam int DivSteps = 3;

    // configuration registers
    logic [COORD_BITS-1:0]   r_rect_left;
    logic [COORD_BITS-1:0]   r_rect_top;
    logic [SizeBits-1:0]     r_rect_width;
    logic [SizeBits-1:0]     r_rect_height;
    logic [31:0]             r_color_first;
    logic [31:0]             r_color_second;
    logic [COORD_BITS-1:0]   r_corner_radius;
    rfps_pkg::t_fill_mode    r_fill_mode;

    rfps_pkg::t_cfg_reg      w_cfg_sel;
    logic                    w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_sel   = rfps_pkg::t_cfg_reg'(paddr[4:2]);
    assign w_cfg_write = psel && penable && pwrite && pready;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left     <= '0;
            r_rect_top      <= '0;
            r_rect_width    <= '0;
            r_rect_height   <= '0;
            r_color_first   <= '0;
            r_color_second  <= '0;
            r_corner_radius <= '0;
            r_fill_mode     <= rfps_pkg::FILL_SOLID;
        end else if (w_cfg_write) begin
            case (w_cfg_sel)
                rfps_pkg::CFG_RECT_LEFT:     r_rect_left     <= pwdata[COORD_BITS-1:0];
                rfps_pkg::CFG_RECT_TOP:      r_rect_top      <= pwdata[COORD_BITS-1:0];
                rfps_pkg::CFG_RECT_WIDTH:    r_rect_width    <= pwdata[SizeBits-1:0];
                rfps_pkg::CFG_RECT_HEIGHT:   r_rect_height   <= pwdata[SizeBits-1:0];
                rfps_pkg::CFG_COLOR_FIRST:   r_color_first   <= pwdata;
                rfps_pkg::CFG_COLOR_SECOND:  r_color_second  <= pwdata;
                rfps_pkg::CFG_CORNER_RADIUS: r_corner_radius <= pwdata[COORD_BITS-1:0];
                rfps_pkg::CFG_FILL_MODE:     r_fill_mode     <= rfps_pkg::t_fill_mode'(pwdata[1:0]);
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        case (w_cfg_sel)
            rfps_pkg::CFG_RECT_LEFT:     prdata = 32'(r_rect_left);
            rfps_pkg::CFG_RECT_TOP:      prdata = 32'(r_rect_top);
            rfps_pkg::CFG_RECT_WIDTH:    prdata = 32'(r_rect_width);
            rfps_pkg::CFG_RECT_HEIGHT:   prdata = 32'(r_rect_height);
            rfps_pkg::CFG_COLOR_FIRST:   prdata = r_color_first;
            rfps_pkg::CFG_COLOR_SECOND:  prdata = r_color_second;
            rfps_pkg::CFG_CORNER_RADIUS: prdata = 32'(r_corner_radius);
            rfps_pkg::CFG_FILL_MODE:     prdata = 32'(r_fill_mode);
            default:                     prdata = '0;
        endcase
    end

    // values derived from configuration, stable while pixels are in flight
    logic [COORD_BITS-1:0] w_div_d;
    logic [SizeBits-1:0]   w_wm1;
    logic [SizeBits-1:0]   w_hm1;
    logic [SizeBits-1:0]   w_min_wh;
    logic [COORD_BITS-1:0] w_max_r;
    logic [COORD_BITS-1:0] w_rad;
    logic [COORD_BITS-1:0] w_rad_m1;
    logic [7:0]            w_alpha;
    logic [7:0]            w_alpha_inv;
    logic                  w_grad_flat;

    assign w_wm1       = r_rect_width - SizeBits'(1);
    assign w_hm1       = r_rect_height - SizeBits'(1);
    assign w_div_d     = w_hm1[COORD_BITS-1:0];
    assign w_min_wh    = (r_rect_width < r_rect_height) ? r_rect_width : r_rect_height;
    assign w_max_r     = w_min_wh[SizeBits-1:1];
    assign w_rad       = (r_corner_radius < w_max_r) ? r_corner_radius : w_max_r;
    assign w_rad_m1    = w_rad - COORD_BITS'(1);
    assign w_alpha     = r_color_first[31:24];
    assign w_alpha_inv = rfps_pkg::CHAN_MAX - w_alpha;
    assign w_grad_flat = (r_rect_height == SizeBits'(1)) || (r_color_first == r_color_second);

    // per-stage advance: a stage loads when it is empty or its successor moves
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_out_valid;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6;

    assign w_rdy6  = !r_out_valid || !i_stall;
    assign w_rdy5  = !r_v5 || w_rdy6;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
            if (w_rdy6) r_out_valid <= r_v5;
        end
    end

    // stage 1: rectangle hit test and offsets inside the rectangle
    logic [COORD_BITS-1:0] n_cx, n_cy;
    logic                  n_in1;
    logic                  r_in1;
    logic [COORD_BITS-1:0] r_cx1, r_cy1;
    logic [31:0]           r_old1;

    assign n_cx  = i_pixel_x - r_rect_left;
    assign n_cy  = i_pixel_y - r_rect_top;
    assign n_in1 = (r_rect_width != '0) && (r_rect_height != '0)
                && (i_pixel_x >= r_rect_left) && (i_pixel_y >= r_rect_top)
                && ({1'b0, n_cx} < r_rect_width) && ({1'b0, n_cy} < r_rect_height);

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_in1  <= n_in1;
            r_cx1  <= n_cx;
            r_cy1  <= n_cy;
            r_old1 <= i_old_pixel;
        end
    end

    // stage 2: first three quotient bits, edge distances, blend products
    logic [RemBits-1:0]  n_rem2;
    logic [TBits-1:0]    n_q2;
    logic [SizeBits-1:0] n_ex2, n_ey2;
    logic [15:0]         n_ps2 [3];
    logic [15:0]         n_pd2 [3];

    logic                r_in2;
    logic [RemBits-1:0]  r_rem2;
    logic [TBits-1:0]    r_q2;
    logic [SizeBits-1:0] r_ex2, r_ey2;
    logic [15:0]         r_ps2 [3];
    logic [15:0]         r_pd2 [3];

    always_comb begin
        logic [RemBits-1:0] rem;
        logic [TBits-1:0]   q;
        rem = {1'b0, r_cy1};
        q   = '0;
        for (int j = 0; j < DivSteps; j++) begin
            if (j != 0) rem = rem << 1;
            if (rem >= {1'b0, w_div_d}) begin
                rem = rem - {1'b0, w_div_d};
                q   = {q[TBits-2:0], 1'b1};
            end else begin
                q   = {q[TBits-2:0], 1'b0};
            end
        end
        n_rem2 = rem;
        n_q2   = q;
    end

    // distance to the nearer vertical and horizontal edge
    always_comb begin
        logic [SizeBits-1:0] fx, fy, bx, by;
        fx    = {1'b0, r_cx1};
        fy    = {1'b0, r_cy1};
        bx    = w_wm1 - fx;
        by    = w_hm1 - fy;
        n_ex2 = (fx < bx) ? fx : bx;
        n_ey2 = (fy < by) ? fy : by;
    end

    // source and destination weights per channel
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_ps2[c] = 16'(r_color_first[8*c +: 8]) * 16'(w_alpha);
            n_pd2[c] = 16'(r_old1[8*c +: 8]) * 16'(w_alpha_inv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_in2  <= r_in1;
            r_rem2 <= n_rem2;
            r_q2   <= n_q2;
            r_ex2  <= n_ex2;
            r_ey2  <= n_ey2;
            for (int c = 0; c < 3; c++) begin
                r_ps2[c] <= n_ps2[c];
                r_pd2[c] <= n_pd2[c];
            end
        end
    end

    // stage 3: next three quotient bits, corner offsets, blend sums
    logic [RemBits-1:0]    n_rem3;
    logic [TBits-1:0]      n_q3;
    logic                  n_corner3;
    logic [15:0]           n_sum3 [3];

    logic                  r_in3;
    logic [RemBits-1:0]    r_rem3;
    logic [TBits-1:0]      r_q3;
    logic                  r_corner3;
    logic [COORD_BITS-1:0] r_vx3, r_vy3;
    logic [15:0]           r_sum3 [3];

    always_comb begin
        logic [RemBits-1:0] rem;
        logic [TBits-1:0]   q;
        rem = r_rem2;
        q   = r_q2;
        for (int j = 0; j < DivSteps; j++) begin
            rem = rem << 1;
            if (rem >= {1'b0, w_div_d}) begin
                rem = rem - {1'b0, w_div_d};
                q   = {q[TBits-2:0], 1'b1};
            end else begin
                q   = {q[TBits-2:0], 1'b0};
            end
        end
        n_rem3 = rem;
        n_q3   = q;
    end

    assign n_corner3 = (w_rad != '0) && (r_ex2 < {1'b0, w_rad}) && (r_ey2 < {1'b0, w_rad});

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum3[c] = r_ps2[c] + r_pd2[c] + rfps_pkg::BLEND_BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_in3     <= r_in2;
            r_rem3    <= n_rem3;
            r_q3      <= n_q3;
            r_corner3 <= n_corner3;
            r_vx3     <= w_rad_m1 - r_ex2[COORD_BITS-1:0];
            r_vy3     <= w_rad_m1 - r_ey2[COORD_BITS-1:0];
            for (int c = 0; c < 3; c++) begin
                r_sum3[c] <= n_sum3[c];
            end
        end
    end

    // stage 4: last three quotient bits, squares, divide by 255
    logic [TBits-1:0]  n_t4;
    logic [31:0]       n_bprod4 [3];

    logic              r_in4;
    logic [TBits-1:0]  r_t4;
    logic              r_corner4;
    logic [SqBits-1:0] r_sqx4, r_sqy4, r_r1sq4;
    logic [7:0]        r_bq4 [3];

    always_comb begin
        logic [RemBits-1:0] rem;
        logic [TBits-1:0]   q;
        rem = r_rem3;
        q   = r_q3;
        for (int j = 0; j < DivSteps; j++) begin
            rem = rem << 1;
            if (rem >= {1'b0, w_div_d}) begin
                rem = rem - {1'b0, w_div_d};
                q   = {q[TBits-2:0], 1'b1};
            end else begin
                q   = {q[TBits-2:0], 1'b0};
            end
        end
        n_t4 = q;
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_bprod4[c] = 32'(r_sum3[c]) * rfps_pkg::BLEND_RECIP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_in4     <= r_in3;
            r_t4      <= n_t4;
            r_corner4 <= r_corner3;
            r_sqx4    <= SqBits'(r_vx3) * SqBits'(r_vx3);
            r_sqy4    <= SqBits'(r_vy3) * SqBits'(r_vy3);
            r_r1sq4   <= SqBits'(w_rad_m1) * SqBits'(w_rad_m1);
            for (int c = 0; c < 3; c++) begin
                r_bq4[c] <= n_bprod4[c][rfps_pkg::BLEND_SHIFT +: 8];
            end
        end
    end

    // stage 5: corner decision and gradient products
    logic                  n_keep5;
    logic signed [9:0]     w_gt;
    logic signed [8:0]     w_gd [3];
    logic signed [18:0]    n_gp5 [3];

    logic                  r_in5;
    logic                  r_keep5;
    logic signed [18:0]    r_gp5 [3];
    logic [7:0]            r_bq5 [3];

    assign n_keep5 = !r_corner4
                  || (({1'b0, r_sqx4} + {1'b0, r_sqy4}) <= {1'b0, r_r1sq4});
    assign w_gt    = $signed({1'b0, r_t4});

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_gd[c]  = $signed({1'b0, r_color_second[8*c +: 8]})
                     - $signed({1'b0, r_color_first[8*c +: 8]});
            n_gp5[c] = w_gd[c] * w_gt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_in5   <= r_in4;
            r_keep5 <= n_keep5;
            for (int c = 0; c < 3; c++) begin
                r_gp5[c] <= n_gp5[c];
                r_bq5[c] <= r_bq4[c];
            end
        end
    end

    // stage 6: mode select into the output register
    logic        n_we6;
    logic [31:0] n_val6;
    logic [23:0] w_grad_rgb;
    logic [23:0] w_blend_rgb;

    always_comb begin
        logic signed [18:0] adj;
        for (int c = 0; c < 3; c++) begin
            // arithmetic shift by 8, rounded toward zero
            adj = r_gp5[c] + (r_gp5[c][18] ? rfps_pkg::GRAD_NEG_BIAS : 19'sd0);
            w_grad_rgb[8*c +: 8]  = r_color_first[8*c +: 8] + adj[15:8];
            w_blend_rgb[8*c +: 8] = r_bq5[c];
        end
    end

    always_comb begin
        n_we6  = 1'b0;
        n_val6 = '0;
        if (r_in5) begin
            case (r_fill_mode)
                rfps_pkg::FILL_SOLID: begin
                    n_we6  = 1'b1;
                    n_val6 = r_color_first;
                end
                rfps_pkg::FILL_ALPHA: begin
                    if (w_alpha == rfps_pkg::CHAN_MAX) begin
                        n_we6  = 1'b1;
                        n_val6 = {8'h00, r_color_first[23:0]};
                    end else if (w_alpha != rfps_pkg::ALPHA_ZERO) begin
                        n_we6  = 1'b1;
                        n_val6 = {8'h00, w_blend_rgb};
                    end
                end
                rfps_pkg::FILL_GRADIENT: begin
                    n_we6  = 1'b1;
                    n_val6 = w_grad_flat ? r_color_first : {8'h00, w_grad_rgb};
                end
                rfps_pkg::FILL_ROUNDED: begin
                    n_we6  = r_keep5;
                    n_val6 = r_keep5 ? r_color_first : 32'h0;
                end
                default: begin
                    n_we6  = 1'b0;
                    n_val6 = '0;
                end
            endcase
        end
    end

    logic        r_we6;
    logic [31:0] r_val6;

    always_ff @(posedge i_clk) begin
        if (w_rdy6) begin
            r_we6  <= n_we6;
            r_val6 <= n_val6;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_write_enable = r_we6;
    assign o_new_pixel    = r_val6;

    // checks

    // a result that writes nothing carries a zero value
    a_idle_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |-> (o_new_pixel == 32'h0))
        else $error("result without write carries a nonzero value");

    // an accepted transaction always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted transaction lost at the first stage");

    // a zero-sized rectangle never writes
    a_empty_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((r_rect_width == '0) || (r_rect_height == '0))) |-> !o_write_enable)
        else $error("write issued for an empty rectangle");

    // transparent alpha never writes
    a_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_fill_mode == rfps_pkg::FILL_ALPHA) && (w_alpha == rfps_pkg::ALPHA_ZERO))
        |-> !o_write_enable)
        else $error("write issued with zero alpha");

endmodule

// ===== test/rect_fill_pixel_shader_tb.sv =====
module rect_fill_pixel_shader_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS  = rfps_pkg::COORD_BITS_DEFAULT;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int PIPE_DEPTH  = 6;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 50;

    // one full register set of the fill
    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS:0]   width;
        logic [COORD_BITS:0]   height;
        logic [31:0]           color_a;
        logic [31:0]           color_b;
        logic [COORD_BITS-1:0] radius;
        rfps_pkg::t_fill_mode  mode;
    } t_fill_cfg;

    typedef struct packed {
        logic        we;
        logic [31:0] pix;
    } t_shade;

    typedef struct packed {
        t_fill_cfg             cfg;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [31:0]           old;
        logic                  has_want;
        t_shade                want;
    } t_pixel_row;

    logic                               i_clk;
    logic                               i_rst_n = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [rfps_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [rfps_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
    logic [rfps_pkg::CFG_DATA_BITS-1:0] prdata;
    logic                               pready;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic [COORD_BITS-1:0]              i_pixel_x = '0;
    logic [COORD_BITS-1:0]              i_pixel_y = '0;
    logic [31:0]                        i_old_pixel = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic                               o_write_enable;
    logic [31:0]                        o_new_pixel;

    t_fill_cfg  fill_cfg;
    t_shade     results_due[$];
    t_pixel_row directed_rows[$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    bit         idle_on = 1'b1;

    rect_fill_pixel_shader #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_old_pixel    (i_old_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_enable (o_write_enable),
        .o_new_pixel    (o_new_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expected shade of one pixel under a given register set
    function automatic t_shade shade_pixel(t_fill_cfg c, logic [COORD_BITS-1:0] x,
                                           logic [COORD_BITS-1:0] y, logic [31:0] old);
        t_shade s;
        int px, py, pl, pt, cx, cy, w, h, a, src, dst, tv, bv, t;
        int max_r, r, r1, ex, ey, vx, vy;
        bit keep;
        s = '0;
        px = x;
        py = y;
        pl = c.left;
        pt = c.top;
        w = c.width;
        h = c.height;
        if (w == 0 || h == 0 || px < pl || py < pt)
            return s;
        cx = px - pl;
        cy = py - pt;
        if (cx >= w || cy >= h)
            return s;
        case (c.mode)
            rfps_pkg::FILL_SOLID: begin
                s.we = 1'b1;
                s.pix = c.color_a;
            end
            rfps_pkg::FILL_ALPHA: begin
                a = c.color_a[31:24];
                if (a == rfps_pkg::CHAN_MAX) begin
                    s.we = 1'b1;
                    s.pix = {8'h00, c.color_a[23:0]};
                end else if (a != rfps_pkg::ALPHA_ZERO) begin
                    s.we = 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        src = c.color_a[8*k +: 8];
                        dst = old[8*k +: 8];
                        s.pix[8*k +: 8] = (src * a + dst * (255 - a) + 127) / 255;
                    end
                end
            end
            rfps_pkg::FILL_GRADIENT: begin
                s.we = 1'b1;
                if (h == 1 || c.color_a == c.color_b) begin
                    s.pix = c.color_a;
                end else begin
                    t = (cy * 256) / (h - 1);
                    // signed division truncates toward zero
                    for (int k = 0; k < 3; k++) begin
                        tv = c.color_a[8*k +: 8];
                        bv = c.color_b[8*k +: 8];
                        s.pix[8*k +: 8] = tv + ((bv - tv) * t) / 256;
                    end
                end
            end
            default: begin
                max_r = (w < h ? w : h) / 2;
                r = c.radius;
                if (r > max_r)
                    r = max_r;
                keep = 1'b1;
                if (r != 0) begin
                    ex = cx < (w - 1 - cx) ? cx : (w - 1 - cx);
                    ey = cy < (h - 1 - cy) ? cy : (h - 1 - cy);
                    // only inside a corner square does the distance test apply
                    if (ex < r && ey < r) begin
                        r1 = r - 1;
                        vx = r1 - ex;
                        vy = r1 - ey;
                        keep = (vx * vx + vy * vy <= r1 * r1);
                    end
                end
                if (keep) begin
                    s.we = 1'b1;
                    s.pix = c.color_a;
                end
            end
        endcase
        return s;
    endfunction

    function automatic t_fill_cfg mk_cfg(int l, int t, int w, int h, logic [31:0] ca,
                                         logic [31:0] cb, int rad, rfps_pkg::t_fill_mode m);
        t_fill_cfg c;
        c.left = l;
        c.top = t;
        c.width = w;
        c.height = h;
        c.color_a = ca;
        c.color_b = cb;
        c.radius = rad;
        c.mode = m;
        return c;
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_origin();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(64);
        if (pick < 95)
            return $urandom_range(COORD_MAX);
        return COORD_MAX;
    endfunction

    // mostly small rectangles, a few disabled or full size
    function automatic logic [COORD_BITS:0] rand_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 0;
        if (pick < 75)
            return $urandom_range(16, 1);
        if (pick < 93)
            return $urandom_range(300, 17);
        if (pick < 97)
            return COORD_MAX + 1;
        return $urandom_range(COORD_MAX + 1, 1);
    endfunction

    function automatic t_fill_cfg rand_cfg(rfps_pkg::t_fill_mode m);
        t_fill_cfg c;
        int pick;
        c.left = rand_origin();
        c.top = rand_origin();
        c.width = rand_size();
        c.height = rand_size();
        c.color_a = $urandom;
        c.color_b = ($urandom_range(3) == 0) ? c.color_a : 32'($urandom);
        c.mode = m;
        pick = $urandom_range(99);
        if (pick < 15)
            c.color_a[31:24] = rfps_pkg::ALPHA_ZERO;
        else if (pick < 30)
            c.color_a[31:24] = rfps_pkg::CHAN_MAX;
        pick = $urandom_range(3);
        if (pick < 2)
            c.radius = $urandom_range(8);
        else if (pick == 2)
            c.radius = $urandom_range(COORD_MAX);
        else
            c.radius = COORD_MAX;
        return c;
    endfunction

    task automatic plan_pixel(t_fill_cfg c, int x, int y, logic [31:0] old,
                              logic has_want, logic we, logic [31:0] pix);
        t_pixel_row row;
        row.cfg = c;
        row.x = x;
        row.y = y;
        row.old = old;
        row.has_want = has_want;
        row.want.we = we;
        row.want.pix = pix;
        directed_rows.push_back(row);
    endtask

    // setup cycle, then access cycle until pready
    task automatic apb_write(rfps_pkg::t_cfg_reg idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // sender stops until every due result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_fill_cfg(t_fill_cfg c);
        rfps_pkg::t_cfg_reg idx;
        logic [31:0] value;
        drain_results();
        repeat (PIPE_DEPTH) @(posedge i_clk);
        for (int i = 0; i < 8; i++) begin
            idx = rfps_pkg::t_cfg_reg'(i);
            case (idx)
                rfps_pkg::CFG_RECT_LEFT:     value = c.left;
                rfps_pkg::CFG_RECT_TOP:      value = c.top;
                rfps_pkg::CFG_RECT_WIDTH:    value = c.width;
                rfps_pkg::CFG_RECT_HEIGHT:   value = c.height;
                rfps_pkg::CFG_COLOR_FIRST:   value = c.color_a;
                rfps_pkg::CFG_COLOR_SECOND:  value = c.color_b;
                rfps_pkg::CFG_CORNER_RADIUS: value = c.radius;
                default:                     value = c.mode;
            endcase
            apb_write(idx, value);
        end
        fill_cfg = c;
    endtask

    task automatic send_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                              logic [31:0] old, logic has_want, t_shade want);
        while (idle_on && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        i_old_pixel <= old;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        results_due.push_back(has_want ? want : shade_pixel(fill_cfg, x, y, old));
    endtask

    // result side stalls at random
    always @(posedge i_clk)
        i_stall <= idle_on && ($urandom_range(99) < 6);

    // compare each result transaction with the oldest one due
    always @(posedge i_clk) begin : check_out
        t_shade due;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: we=%0b pixel=%h", o_write_enable, o_new_pixel);
            end else begin
                due = results_due.pop_front();
                if (o_write_enable !== due.we || o_new_pixel !== due.pix) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: we exp %0b got %0b, pixel exp %h got %h",
                                 due.we, o_write_enable, due.pix, o_new_pixel);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_fill_cfg reset_c, solid_c, a0_c, af_c, ab_c, ab1_c, ab254_c;
        t_fill_cfg gflat_c, geq_c, grad_c, rnd_c, rnd0_c, wide_c, phase_c;
        int lo_x, hi_x, lo_y, hi_y, x, y;

        reset_c = '0;
        solid_c = mk_cfg(10, 20, 5, 4, 32'hDEAD_BEEF, 32'h0, 0, rfps_pkg::FILL_SOLID);
        a0_c    = mk_cfg(10, 20, 5, 4, 32'h0012_3456, 32'h0, 0, rfps_pkg::FILL_ALPHA);
        af_c    = mk_cfg(10, 20, 5, 4, 32'hFF12_3456, 32'h0, 0, rfps_pkg::FILL_ALPHA);
        ab_c    = mk_cfg(10, 20, 5, 4, 32'h80FF_4000, 32'h0, 0, rfps_pkg::FILL_ALPHA);
        ab1_c   = mk_cfg(10, 20, 5, 4, 32'h01FF_FFFF, 32'h0, 0, rfps_pkg::FILL_ALPHA);
        ab254_c = mk_cfg(10, 20, 5, 4, 32'hFE00_0000, 32'h0, 0, rfps_pkg::FILL_ALPHA);
        gflat_c = mk_cfg(10, 20, 5, 1, 32'hAA11_2233, 32'h00FF_00FF, 0,
                         rfps_pkg::FILL_GRADIENT);
        geq_c   = mk_cfg(10, 20, 5, 4, 32'h5566_7788, 32'h5566_7788, 0,
                         rfps_pkg::FILL_GRADIENT);
        grad_c  = mk_cfg(10, 20, 5, 5, 32'h12FF_0010, 32'h3400_FFF0, 0,
                         rfps_pkg::FILL_GRADIENT);
        rnd_c   = mk_cfg(0, 0, 8, 8, 32'h1122_3344, 32'h0, COORD_MAX, rfps_pkg::FILL_ROUNDED);
        rnd0_c  = mk_cfg(0, 0, 8, 8, 32'h1122_3344, 32'h0, 0, rfps_pkg::FILL_ROUNDED);
        wide_c  = mk_cfg(COORD_MAX, COORD_MAX, COORD_MAX + 1, COORD_MAX + 1,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, rfps_pkg::FILL_SOLID);

        // after reset the fill is disabled
        plan_pixel(reset_c, 0, 0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0);
        plan_pixel(reset_c, COORD_MAX, COORD_MAX, 32'h0, 1'b1, 1'b0, 32'h0);
        // solid fill, corners and just outside each edge
        plan_pixel(solid_c, 10, 20, 32'h0, 1'b1, 1'b1, 32'hDEAD_BEEF);
        plan_pixel(solid_c, 14, 23, 32'h1234_5678, 1'b1, 1'b1, 32'hDEAD_BEEF);
        plan_pixel(solid_c, 15, 20, 32'h0, 1'b1, 1'b0, 32'h0);
        plan_pixel(solid_c, 9, 20, 32'h0, 1'b1, 1'b0, 32'h0);
        plan_pixel(solid_c, 10, 24, 32'h0, 1'b1, 1'b0, 32'h0);
        plan_pixel(solid_c, 12, 19, 32'h0, 1'b1, 1'b0, 32'h0);
        // alpha zero, alpha full, blends
        plan_pixel(a0_c, 11, 21, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0);
        plan_pixel(af_c, 11, 21, 32'hAABB_CCDD, 1'b1, 1'b1, 32'h0012_3456);
        plan_pixel(ab_c, 10, 20, 32'h0000_0000, 1'b0, 1'b0, 32'h0);
        plan_pixel(ab_c, 14, 23, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0);
        plan_pixel(ab_c, 12, 21, 32'hA5C3_1E78, 1'b0, 1'b0, 32'h0);
        plan_pixel(ab1_c, 10, 20, 32'h0, 1'b0, 1'b0, 32'h0);
        plan_pixel(ab254_c, 10, 20, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0);
        // gradient: single row, equal colors, then top, middle and bottom rows
        plan_pixel(gflat_c, 12, 20, 32'h0, 1'b1, 1'b1, 32'hAA11_2233);
        plan_pixel(geq_c, 12, 22, 32'h0, 1'b1, 1'b1, 32'h5566_7788);
        plan_pixel(grad_c, 10, 20, 32'h0, 1'b0, 1'b0, 32'h0);
        plan_pixel(grad_c, 10, 22, 32'h0, 1'b0, 1'b0, 32'h0);
        plan_pixel(grad_c, 10, 24, 32'h0, 1'b0, 1'b0, 32'h0);
        // rounded: radius clamped to 4, outer corner cut, rim kept, center
        plan_pixel(rnd_c, 0, 0, 32'h0, 1'b1, 1'b0, 32'h0);
        plan_pixel(rnd_c, 1, 1, 32'h0, 1'b0, 1'b0, 32'h0);
        plan_pixel(rnd_c, 7, 3, 32'h0, 1'b0, 1'b0, 32'h0);
        plan_pixel(rnd_c, 4, 4, 32'h0, 1'b1, 1'b1, 32'h1122_3344);
        plan_pixel(rnd0_c, 0, 0, 32'h0, 1'b1, 1'b1, 32'h1122_3344);
        // rectangle reaching past the last column and row
        plan_pixel(wide_c, COORD_MAX, COORD_MAX, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        plan_pixel(wide_c, COORD_MAX - 1, COORD_MAX, 32'h0, 1'b1, 1'b0, 32'h0);

        fill_cfg = reset_c;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pixels
        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg != fill_cfg)
                load_fill_cfg(directed_rows[i].cfg);
            send_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].old,
                       directed_rows[i].has_want, directed_rows[i].want);
        end

        // random phases, each with a fresh register set
        for (int p = 0; p < PHASES; p++) begin
            phase_c = rand_cfg(rfps_pkg::t_fill_mode'(p % 4));
            load_fill_cfg(phase_c);
            idle_on = !(p >= 4 && p <= 6);
            lo_x = (phase_c.left > 0) ? phase_c.left - 1 : 0;
            hi_x = phase_c.left + phase_c.width;
            lo_y = (phase_c.top > 0) ? phase_c.top - 1 : 0;
            hi_y = phase_c.top + phase_c.height;
            if (hi_x > COORD_MAX)
                hi_x = COORD_MAX;
            if (hi_y > COORD_MAX)
                hi_y = COORD_MAX;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2)
                    drain_results();
                if ($urandom_range(99) < 80) begin
                    x = $urandom_range(hi_x, lo_x);
                    y = $urandom_range(hi_y, lo_y);
                end else begin
                    x = $urandom_range(COORD_MAX);
                    y = $urandom_range(COORD_MAX);
                end
                send_pixel(x, y, $urandom, 1'b0, '0);
            end
        end

        drain_results();
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);
        if (results_due.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== rect_fill_pixel_shader.f =====
hw/rtl/rfps_pkg.sv
hw/rtl/rect_fill_pixel_shader.sv
test/rect_fill_pixel_shader_tb.sv
